// ----- rtl/pld_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pld_pkg
// Types and constants for the point light diffuse shader.
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int unsigned SqrtSteps = 25;
  localparam int unsigned CosBits   = 17;
  localparam int unsigned ChanBits  = 16;

  localparam logic [1:0] RegLightX     = 2'd0;
  localparam logic [1:0] RegLightY     = 2'd1;
  localparam logic [1:0] RegLightZ     = 2'd2;
  localparam logic [1:0] RegLightPower = 2'd3;

  localparam logic [16:0] CosOne  = 17'd65536;
  localparam logic [15:0] ChanMax = 16'hFFFF;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        base_red;
    logic [15:0]        base_green;
    logic [15:0]        base_blue;
  } in_t;

  typedef struct packed {
    logic [15:0] lit_red;
    logic [15:0] lit_green;
    logic [15:0] lit_blue;
  } out_t;

  typedef struct packed {
    logic                    v;
    logic [2:0][24:0]        d;
    logic [2:0][15:0]        n;
    logic [2:0][15:0]        base;
  } dif_t;

  typedef struct packed {
    logic                    v;
    logic [2:0][49:0]        sq;
    logic [2:0][40:0]        pr;
    logic [2:0][15:0]        base;
  } prd_t;

  typedef struct packed {
    logic                    v;
    logic [28:0]             rem;
    logic [24:0]             root;
    logic [49:0]             dsq;
    logic [42:0]             numc;
    logic                    kill;
    logic [2:0][15:0]        base;
  } sqs_t;

  typedef struct packed {
    logic                    v;
    logic [42:0]             rem;
    logic [16:0]             q;
    logic [24:0]             len;
    logic                    ovf;
    logic [49:0]             dsq;
    logic                    kill;
    logic [2:0][15:0]        base;
  } dv1_t;

  typedef struct packed {
    logic                    v;
    logic [2:0][32:0]        p;
    logic [49:0]             dsq;
    logic                    kill;
  } ml1_t;

  typedef struct packed {
    logic                    v;
    logic [2:0][48:0]        p;
    logic [49:0]             dsq;
    logic                    kill;
  } ml2_t;

  typedef struct packed {
    logic                    v;
    logic [2:0][56:0]        rem;
    logic [2:0][15:0]        q;
    logic [2:0]              ovf;
    logic [49:0]             dsq;
    logic                    kill;
  } dv2_t;

endpackage

`default_nettype wire

// ----- rtl/point_light_diffuse_shader.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// point_light_diffuse_shader
// Lambert diffuse shading of one surface point lit by one point light.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted every cycle unless the pipe holds;
// each passes input difference, multiply, sum, 25 square root stages, 18
// cosine divide stages, two color multiply stages, 17 channel divide stages
// and the output register. The whole pipe advances together; it holds when
// the output item is valid and stalled. Light registers are sampled as items
// pass, so write them only while the pipe is empty.
module point_light_diffuse_shader (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  pld_pkg::in_t        in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output pld_pkg::out_t       out_data_o,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [23:0]    cfg_data_i
);
  import pld_pkg::*;

  logic [23:0] light_x_q, light_y_q, light_z_q;
  logic [15:0] light_pw_q;

  dif_t dif_q, dif_d;
  prd_t prd_q, prd_d;
  sqs_t sq0_d;
  sqs_t sq_q [SqrtSteps+1];
  sqs_t sq_d [SqrtSteps+1];
  dv1_t d1_q [CosBits+1];
  dv1_t d1_d [CosBits+1];
  ml1_t m1_q, m1_d;
  ml2_t m2_q, m2_d;
  dv2_t d2_q [ChanBits+1];
  dv2_t d2_d [ChanBits+1];
  logic out_v_q, out_v_d;
  out_t out_q, out_d;
  logic en;

  assign en          = !(out_v_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q  <= 24'd131072;
      light_y_q  <= 24'd65536;
      light_z_q  <= 24'd131072;
      light_pw_q <= 16'd2560;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLightX:     light_x_q  <= cfg_data_i;
        RegLightY:     light_y_q  <= cfg_data_i;
        RegLightZ:     light_z_q  <= cfg_data_i;
        RegLightPower: light_pw_q <= cfg_data_i[15:0];
        default:       ;
      endcase
    end
  end

  // front: differences, products, sums
  always_comb begin
    logic signed [41:0] dot;
    logic [49:0]        dsq;
    dif_d.v       = in_valid_i;
    dif_d.d[0]    = {light_x_q[23], light_x_q} - {in_data_i.pos_x[23], in_data_i.pos_x};
    dif_d.d[1]    = {light_y_q[23], light_y_q} - {in_data_i.pos_y[23], in_data_i.pos_y};
    dif_d.d[2]    = {light_z_q[23], light_z_q} - {in_data_i.pos_z[23], in_data_i.pos_z};
    dif_d.n[0]    = in_data_i.norm_x;
    dif_d.n[1]    = in_data_i.norm_y;
    dif_d.n[2]    = in_data_i.norm_z;
    dif_d.base[0] = in_data_i.base_red;
    dif_d.base[1] = in_data_i.base_green;
    dif_d.base[2] = in_data_i.base_blue;

    prd_d.v    = dif_q.v;
    prd_d.base = dif_q.base;
    for (int k = 0; k < 3; k++) begin
      prd_d.sq[k] = 50'($signed(dif_q.d[k]) * $signed(dif_q.d[k]));
      prd_d.pr[k] = 41'($signed(dif_q.n[k]) * $signed(dif_q.d[k]));
    end

    dsq = prd_q.sq[0] + prd_q.sq[1] + prd_q.sq[2];
    dot = 42'($signed(prd_q.pr[0])) + 42'($signed(prd_q.pr[1]))
        + 42'($signed(prd_q.pr[2]));
    sq0_d.v    = prd_q.v;
    sq0_d.rem  = '0;
    sq0_d.root = '0;
    sq0_d.dsq  = dsq;
    sq0_d.kill = (dsq == '0) || (dot <= 42'sd0);
    sq0_d.numc = (dot > 42'sd0) ? {dot[40:0], 2'b00} : '0;
    sq0_d.base = prd_q.base;
  end

  // square root, one result bit per stage
  always_comb begin
    logic [28:0] t;
    logic [28:0] trial;
    sq_d[0] = sq0_d;
    for (int k = 0; k < SqrtSteps; k++) begin
      sq_d[k+1] = sq_q[k];
      t     = {sq_q[k].rem[26:0], sq_q[k].dsq[49-2*k -: 2]};
      trial = {2'b00, sq_q[k].root, 2'b01};
      if (t >= trial) begin
        sq_d[k+1].rem  = t - trial;
        sq_d[k+1].root = {sq_q[k].root[23:0], 1'b1};
      end else begin
        sq_d[k+1].rem  = t;
        sq_d[k+1].root = {sq_q[k].root[23:0], 1'b0};
      end
    end
  end

  // cosine divide: numc / len, quotient clamped
  always_comb begin
    logic [43:0] sub;
    d1_d[0].v    = sq_q[SqrtSteps].v;
    d1_d[0].rem  = sq_q[SqrtSteps].numc;
    d1_d[0].q    = '0;
    d1_d[0].len  = sq_q[SqrtSteps].root;
    d1_d[0].ovf  = {1'b0, sq_q[SqrtSteps].numc} >= {2'b00, sq_q[SqrtSteps].root, 17'd0};
    d1_d[0].dsq  = sq_q[SqrtSteps].dsq;
    d1_d[0].kill = sq_q[SqrtSteps].kill;
    d1_d[0].base = sq_q[SqrtSteps].base;
    for (int j = 0; j < CosBits; j++) begin
      d1_d[j+1] = d1_q[j];
      sub = {19'd0, d1_q[j].len} << (CosBits - 1 - j);
      if ({1'b0, d1_q[j].rem} >= sub) begin
        d1_d[j+1].rem = 43'({1'b0, d1_q[j].rem} - sub);
        d1_d[j+1].q   = {d1_q[j].q[15:0], 1'b1};
      end else begin
        d1_d[j+1].q   = {d1_q[j].q[15:0], 1'b0};
      end
    end
  end

  // color scaling
  always_comb begin
    logic [16:0] cosv;
    if (d1_q[CosBits].kill) begin
      cosv = '0;
    end else if (d1_q[CosBits].ovf || d1_q[CosBits].q > CosOne) begin
      cosv = CosOne;
    end else begin
      cosv = d1_q[CosBits].q;
    end
    m1_d.v    = d1_q[CosBits].v;
    m1_d.dsq  = d1_q[CosBits].dsq;
    m1_d.kill = d1_q[CosBits].kill;
    for (int k = 0; k < 3; k++) begin
      m1_d.p[k] = 33'(d1_q[CosBits].base[k] * cosv);
    end
    m2_d.v    = m1_q.v;
    m2_d.dsq  = m1_q.dsq;
    m2_d.kill = m1_q.kill;
    for (int k = 0; k < 3; k++) begin
      m2_d.p[k] = 49'(m1_q.p[k] * light_pw_q);
    end
  end

  // channel divide: num / dsq, quotient saturated
  always_comb begin
    logic [65:0] sub;
    d2_d[0].v    = m2_q.v;
    d2_d[0].q    = '0;
    d2_d[0].dsq  = m2_q.dsq;
    d2_d[0].kill = m2_q.kill;
    for (int k = 0; k < 3; k++) begin
      d2_d[0].rem[k] = {m2_q.p[k], 8'd0};
      d2_d[0].ovf[k] = {9'd0, m2_q.p[k], 8'd0} >= {m2_q.dsq, 16'd0};
    end
    for (int j = 0; j < ChanBits; j++) begin
      d2_d[j+1] = d2_q[j];
      sub = {16'd0, d2_q[j].dsq} << (ChanBits - 1 - j);
      for (int k = 0; k < 3; k++) begin
        if ({9'd0, d2_q[j].rem[k]} >= sub) begin
          d2_d[j+1].rem[k] = 57'({9'd0, d2_q[j].rem[k]} - sub);
          d2_d[j+1].q[k]   = {d2_q[j].q[k][14:0], 1'b1};
        end else begin
          d2_d[j+1].q[k]   = {d2_q[j].q[k][14:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic [2:0][15:0] ch;
    for (int k = 0; k < 3; k++) begin
      if (d2_q[ChanBits].kill) begin
        ch[k] = '0;
      end else if (d2_q[ChanBits].ovf[k]) begin
        ch[k] = ChanMax;
      end else begin
        ch[k] = d2_q[ChanBits].q[k];
      end
    end
    out_v_d             = d2_q[ChanBits].v;
    out_d.lit_red       = ch[0];
    out_d.lit_green     = ch[1];
    out_d.lit_blue      = ch[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dif_q   <= '0;
      prd_q   <= '0;
      m1_q    <= '0;
      m2_q    <= '0;
      out_v_q <= 1'b0;
      out_q   <= '0;
      for (int k = 0; k <= SqrtSteps; k++) sq_q[k] <= '0;
      for (int j = 0; j <= CosBits; j++) d1_q[j] <= '0;
      for (int j = 0; j <= ChanBits; j++) d2_q[j] <= '0;
    end else if (en) begin
      dif_q   <= dif_d;
      prd_q   <= prd_d;
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      out_v_q <= out_v_d;
      out_q   <= out_d;
      for (int k = 0; k <= SqrtSteps; k++) sq_q[k] <= sq_d[k];
      for (int j = 0; j <= CosBits; j++) d1_q[j] <= d1_d[j];
      for (int j = 0; j <= ChanBits; j++) d2_q[j] <= d2_d[j];
    end
  end

endmodule

`default_nettype wire
